[sv/tto_pkg.sv]
// Shared constants for the triangle overlap pipeline.
`timescale 1ns / 1ps

package tto_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int N_FIELDS       = 12;

  // Cross-product slots: edge-pair denominators, both numerators, then the
  // edge functions for a0 against B and for b0 against A.
  localparam int N_PAIRS = 9;
  localparam int K_DEN   = 0;
  localparam int K_NT    = K_DEN + N_PAIRS;
  localparam int K_NU    = K_NT + N_PAIRS;
  localparam int K_EA    = K_NU + N_PAIRS;
  localparam int K_EB    = K_EA + 3;
  localparam int N_CROSS = K_EB + 3;

endpackage

[sv/triangle_triangle_overlap_top.sv]
// Triangle pair overlap test, five-stage stream pipeline.
`timescale 1ns / 1ps

// Takes one triangle pair per cycle when the output side keeps up and gives
// one overlap flag per pair, presented from the output register once the pair
// has passed through every stage. The stages are input capture, edge and
// offset vectors, the multiplier bank (66 signed products of two COORD_BITS+1
// bit operands), the cross-product subtractors, and the range and sign checks
// feeding the output register. Each stage holds its own valid bit and only
// stalls when the stage after it is full and blocked, so back-pressure fills
// bubbles before it reaches s_tready. Parallel edge pairs never count as
// crossing; a point on an edge or vertex counts as inside.
module triangle_triangle_overlap_top #(
  parameter int COORD_BITS = tto_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // a_x0, a_y0, a_x1, a_y1, a_x2, a_y2, b_x0, b_y0, b_x1, b_y1, b_x2, b_y2
  input  logic [((tto_pkg::N_FIELDS * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // overlap, zero fill
  output logic [7:0] m_tdata
);
  import tto_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int PW = 2 * W + 2;
  localparam int XW = 2 * W + 3;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [W:0]    ax [3];
  logic signed [W:0]    ay [3];
  logic signed [W:0]    bx [3];
  logic signed [W:0]    by [3];
  logic signed [W:0]    c_ux [N_CROSS];
  logic signed [W:0]    c_uy [N_CROSS];
  logic signed [W:0]    c_vx [N_CROSS];
  logic signed [W:0]    c_vy [N_CROSS];
  logic signed [W:0]    ux [N_CROSS];
  logic signed [W:0]    uy [N_CROSS];
  logic signed [W:0]    vx [N_CROSS];
  logic signed [W:0]    vy [N_CROSS];
  logic signed [PW-1:0] pl [N_CROSS];
  logic signed [PW-1:0] pr [N_CROSS];
  logic signed [XW-1:0] cr [N_CROSS];
  logic [N_PAIRS-1:0]   crosses;
  logic                 in_b, in_a, hit;
  logic                 overlap;

  // Each stage loads when empty or when its contents move on.
  assign rdy5     = !v5 || m_tready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v5;
  assign m_tdata  = {7'd0, overlap};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Capture coordinates, sign-extended by one bit for the differences.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 3; i++) begin
        ax[i] <= $signed({s_tdata[(2 * i + 1) * W - 1], s_tdata[(2 * i) * W +: W]});
        ay[i] <= $signed({s_tdata[(2 * i + 2) * W - 1], s_tdata[(2 * i + 1) * W +: W]});
        bx[i] <= $signed({s_tdata[(2 * i + 7) * W - 1], s_tdata[(2 * i + 6) * W +: W]});
        by[i] <= $signed({s_tdata[(2 * i + 8) * W - 1], s_tdata[(2 * i + 7) * W +: W]});
      end
    end
  end

  genvar gi, gj;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_a
      localparam int IN = (gi + 1) % 3;
      for (gj = 0; gj < 3; gj++) begin : g_b
        localparam int JN = (gj + 1) % 3;
        localparam int P  = gi * 3 + gj;
        // den = r x s, nt = d x s, nu = d x r
        assign c_ux[K_DEN + P] = ax[IN] - ax[gi];
        assign c_uy[K_DEN + P] = ay[IN] - ay[gi];
        assign c_vx[K_DEN + P] = bx[JN] - bx[gj];
        assign c_vy[K_DEN + P] = by[JN] - by[gj];
        assign c_ux[K_NT + P]  = bx[gj] - ax[gi];
        assign c_uy[K_NT + P]  = by[gj] - ay[gi];
        assign c_vx[K_NT + P]  = bx[JN] - bx[gj];
        assign c_vy[K_NT + P]  = by[JN] - by[gj];
        assign c_ux[K_NU + P]  = bx[gj] - ax[gi];
        assign c_uy[K_NU + P]  = by[gj] - ay[gi];
        assign c_vx[K_NU + P]  = ax[IN] - ax[gi];
        assign c_vy[K_NU + P]  = ay[IN] - ay[gi];
      end
      // Edge functions: (p - t[m+1]) x (t[m] - t[m+1]).
      assign c_ux[K_EA + gi] = ax[0] - bx[IN];
      assign c_uy[K_EA + gi] = ay[0] - by[IN];
      assign c_vx[K_EA + gi] = bx[gi] - bx[IN];
      assign c_vy[K_EA + gi] = by[gi] - by[IN];
      assign c_ux[K_EB + gi] = bx[0] - ax[IN];
      assign c_uy[K_EB + gi] = by[0] - ay[IN];
      assign c_vx[K_EB + gi] = ax[gi] - ax[IN];
      assign c_vy[K_EB + gi] = ay[gi] - ay[IN];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int k = 0; k < N_CROSS; k++) begin
        ux[k] <= c_ux[k];
        uy[k] <= c_uy[k];
        vx[k] <= c_vx[k];
        vy[k] <= c_vy[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int k = 0; k < N_CROSS; k++) begin
        pl[k] <= ux[k] * vy[k];
        pr[k] <= uy[k] * vx[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int k = 0; k < N_CROSS; k++) begin
        cr[k] <= $signed({pl[k][PW-1], pl[k]}) - $signed({pr[k][PW-1], pr[k]});
      end
    end
  end

  // Range checks without division (numerator in 0..den), then edge signs.
  always_comb begin
    logic dpos, dzero, t_ok, u_ok;
    logic neg_b, pos_b, neg_a, pos_a;
    for (int p = 0; p < N_PAIRS; p++) begin
      dpos  = !cr[K_DEN + p][XW-1] && (cr[K_DEN + p] != '0);
      dzero = (cr[K_DEN + p] == '0);
      if (dpos) begin
        t_ok = !cr[K_NT + p][XW-1] && (cr[K_NT + p] <= cr[K_DEN + p]);
        u_ok = !cr[K_NU + p][XW-1] && (cr[K_NU + p] <= cr[K_DEN + p]);
      end else begin
        t_ok = (cr[K_NT + p] <= 0) && (cr[K_NT + p] >= cr[K_DEN + p]);
        u_ok = (cr[K_NU + p] <= 0) && (cr[K_NU + p] >= cr[K_DEN + p]);
      end
      crosses[p] = !dzero && t_ok && u_ok;
    end
    neg_b = 1'b0;
    pos_b = 1'b0;
    neg_a = 1'b0;
    pos_a = 1'b0;
    for (int m = 0; m < 3; m++) begin
      neg_b = neg_b || cr[K_EA + m][XW-1];
      pos_b = pos_b || (!cr[K_EA + m][XW-1] && (cr[K_EA + m] != '0));
      neg_a = neg_a || cr[K_EB + m][XW-1];
      pos_a = pos_a || (!cr[K_EB + m][XW-1] && (cr[K_EB + m] != '0));
    end
    in_b = !(neg_b && pos_b);
    in_a = !(neg_a && pos_a);
    hit  = (|crosses) || in_b || in_a;
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      overlap <= hit;
    end
  end

  a_hold_stalled : assert property (@(posedge clk) disable iff (rst)
    v4 && !rdy5 |=> v4)
    else $error("stalled stage four lost its item");

  a_empty_out_ready : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while the output register is empty");

  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted transfer did not enter the pipeline");

  a_advance_out : assert property (@(posedge clk) disable iff (rst)
    v4 && rdy5 |=> m_tvalid)
    else $error("result did not reach the output register");

endmodule
